### sv/assert_macros.svh
// Assertion helpers: clocked on clk, quiet while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GMST_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define GMST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GMST_ASSERT_IMPLY(lbl, ante, cons, msg)
`define GMST_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### sv/gmst_pkg.sv
`default_nettype none
package gmst_pkg;

  localparam int SAMPLE_W = 32;
  localparam int ROW_W    = 16;
  localparam int COL_W    = 10;
  localparam int METRIC_W = 36;
  localparam int SQ_W     = 34;
  localparam int QDEPTH   = 4;
  localparam int QAW      = $clog2(QDEPTH);
  localparam int QCW      = $clog2(QDEPTH + 1);

  // Which grid position a result belongs to, relative to the input position.
  typedef enum logic [1:0] {
    RES_UP,
    RES_LEFT,
    RES_HERE
  } res_kind_t;

  typedef enum logic [1:0] {
    DM_ZERO,
    DM_ONE,
    DM_CEN
  } diff_mode_t;

  // Column stencil of the row above.
  typedef enum logic [1:0] {
    EY_ZERO,
    EY_FIRST,
    EY_LAST,
    EY_MID
  } ey_sel_t;

  typedef struct packed {
    logic [1:0] n;
    res_kind_t  kind0;
    res_kind_t  kind1;
    res_kind_t  kind2;
    logic       r_is1;
    logic       rgt1;
    logic       cgt1;
    logic       c_is1;
    ey_sel_t    ey_sel;
  } item_class_t;

  typedef struct packed {
    item_class_t         cls;
    logic [SAMPLE_W-1:0] cur;
    logic [SAMPLE_W-1:0] up;
    logic [SAMPLE_W-1:0] r2;
    logic [SAMPLE_W-1:0] pn;
    logic [SAMPLE_W-1:0] pm1;
    logic [SAMPLE_W-1:0] rs0;
    logic [SAMPLE_W-1:0] rs1;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
  } entry_t;

  // One component of a difference in units of 2^-16.
  function automatic logic signed [17:0] comp_diff(input logic [15:0] a,
                                                   input logic [15:0] b,
                                                   input diff_mode_t m);
    logic signed [16:0] d;
    d = $signed({a[15], a}) - $signed({b[15], b});
    case (m)
      DM_ONE:  comp_diff = {d, 1'b0};
      DM_CEN:  comp_diff = {d[16], d};
      default: comp_diff = '0;
    endcase
  endfunction

endpackage
`default_nettype wire

### sv/gmst_line_mem.sv
`default_nettype none
module gmst_line_mem #(
  parameter int DEPTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]      rd_addr_a,
  input  wire logic [$clog2(DEPTH)-1:0]      rd_addr_b,
  output logic [gmst_pkg::SAMPLE_W-1:0]      rd_data_a,
  output logic [gmst_pkg::SAMPLE_W-1:0]      rd_data_b,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  wire logic [gmst_pkg::SAMPLE_W-1:0] wr_data
);

  logic [gmst_pkg::SAMPLE_W-1:0] mem [DEPTH];

  // Read returns the old word on a same-address write.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

### sv/gmst_front.sv
`default_nettype none
module gmst_front #(
  parameter int MAX_COLS = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          restart,
  input  wire logic [gmst_pkg::ROW_W-1:0]    eff_rows,
  input  wire logic [$clog2(MAX_COLS):0]     eff_cols,
  input  wire logic                          s_valid,
  input  wire logic [gmst_pkg::SAMPLE_W-1:0] s_data,
  output logic                               s_ready,
  input  wire logic                          q_full,
  output logic                               q_push,
  output gmst_pkg::entry_t                   q_entry
);

  localparam int CW = $clog2(MAX_COLS);

  logic [gmst_pkg::ROW_W-1:0]    row_pos;
  logic [CW-1:0]                 col_pos;
  logic [gmst_pkg::SAMPLE_W-1:0] rs0;
  logic [gmst_pkg::SAMPLE_W-1:0] rs1;
  logic [gmst_pkg::SAMPLE_W-1:0] pm1;

  logic                          f1_vld;
  logic                          f1_par;
  logic [gmst_pkg::SAMPLE_W-1:0] f1_cur;
  logic [gmst_pkg::SAMPLE_W-1:0] f1_rs0;
  logic [gmst_pkg::SAMPLE_W-1:0] f1_rs1;
  logic [gmst_pkg::ROW_W-1:0]    f1_row;
  logic [gmst_pkg::COL_W-1:0]    f1_col;
  gmst_pkg::item_class_t         f1_cls;

  logic [gmst_pkg::ROW_W-1:0]    r;
  logic [CW-1:0]                 c;
  logic [CW-1:0]                 c_plus;
  logic                          r_last;
  logic                          c_last;
  logic                          has_a;
  logic                          has_b;
  logic                          has_c;
  logic                          accept;
  logic                          f1_leave;
  gmst_pkg::item_class_t         cls;

  logic [gmst_pkg::SAMPLE_W-1:0] b0_a;
  logic [gmst_pkg::SAMPLE_W-1:0] b0_b;
  logic [gmst_pkg::SAMPLE_W-1:0] b1_a;
  logic [gmst_pkg::SAMPLE_W-1:0] b1_b;
  logic [gmst_pkg::SAMPLE_W-1:0] prev_a;

  // Classify the incoming position.
  always_comb begin
    if (row_pos >= eff_rows || {1'b0, col_pos} >= eff_cols) begin
      r = '0;
      c = '0;
    end else begin
      r = row_pos;
      c = col_pos;
    end
    c_plus = c + CW'(1);
    r_last = (r == eff_rows - gmst_pkg::ROW_W'(1));
    c_last = ({1'b0, c} == eff_cols - (CW + 1)'(1));
    has_a  = (r != '0);
    has_b  = r_last && (c != '0);
    has_c  = r_last && c_last;

    cls.n      = 2'({1'b0, has_a} + {1'b0, has_b} + {1'b0, has_c});
    cls.kind0  = has_a ? gmst_pkg::RES_UP :
                 (has_b ? gmst_pkg::RES_LEFT : gmst_pkg::RES_HERE);
    cls.kind1  = (has_a && has_b) ? gmst_pkg::RES_LEFT : gmst_pkg::RES_HERE;
    cls.kind2  = gmst_pkg::RES_HERE;
    cls.r_is1  = (r == gmst_pkg::ROW_W'(1));
    cls.rgt1   = (eff_rows != gmst_pkg::ROW_W'(1));
    cls.cgt1   = (eff_cols != (CW + 1)'(1));
    cls.c_is1  = (c == CW'(1));
    if (!cls.cgt1) begin
      cls.ey_sel = gmst_pkg::EY_ZERO;
    end else if (c == '0) begin
      cls.ey_sel = gmst_pkg::EY_FIRST;
    end else if (c_last) begin
      cls.ey_sel = gmst_pkg::EY_LAST;
    end else begin
      cls.ey_sel = gmst_pkg::EY_MID;
    end
  end

  assign f1_leave = !f1_vld || (f1_cls.n == 2'd0) || !q_full;
  assign s_ready  = f1_leave;
  assign accept   = s_valid && s_ready;
  assign q_push   = f1_vld && (f1_cls.n != 2'd0) && !q_full;

  // Two row banks chosen by row parity.
  gmst_line_mem #(.DEPTH(MAX_COLS)) u_bank0 (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr_a (c),
    .rd_addr_b (c_plus),
    .rd_data_a (b0_a),
    .rd_data_b (b0_b),
    .wr_en     (accept && !r[0]),
    .wr_addr   (c),
    .wr_data   (s_data)
  );

  gmst_line_mem #(.DEPTH(MAX_COLS)) u_bank1 (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr_a (c),
    .rd_addr_b (c_plus),
    .rd_data_a (b1_a),
    .rd_data_b (b1_b),
    .wr_en     (accept && r[0]),
    .wr_addr   (c),
    .wr_data   (s_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (restart) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (accept) begin
      if (c_last) begin
        col_pos <= '0;
        row_pos <= r_last ? '0 : r + gmst_pkg::ROW_W'(1);
      end else begin
        col_pos <= c_plus;
        row_pos <= r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
    end else if (accept) begin
      f1_vld <= 1'b1;
    end else if (f1_leave) begin
      f1_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rs1    <= rs0;
      rs0    <= s_data;
      f1_cur <= s_data;
      f1_rs0 <= rs0;
      f1_rs1 <= rs1;
      f1_row <= r;
      f1_col <= gmst_pkg::COL_W'(c);
      f1_par <= r[0];
      f1_cls <= cls;
    end
    // Keep the row-above word of the previous column.
    if (f1_vld && f1_leave) begin
      pm1 <= prev_a;
    end
  end

  assign prev_a = f1_par ? b0_a : b1_a;

  always_comb begin
    q_entry.cls = f1_cls;
    q_entry.cur = f1_cur;
    q_entry.up  = prev_a;
    q_entry.r2  = f1_par ? b1_a : b0_a;
    q_entry.pn  = f1_par ? b0_b : b1_b;
    q_entry.pm1 = pm1;
    q_entry.rs0 = f1_rs0;
    q_entry.rs1 = f1_rs1;
    q_entry.row = f1_row;
    q_entry.col = f1_col;
  end

endmodule
`default_nettype wire

### sv/gmst_fifo.sv
`default_nettype none
module gmst_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire gmst_pkg::entry_t  push_entry,
  output logic                   full,
  input  wire logic              pop,
  output logic                   valid,
  output gmst_pkg::entry_t       head
);

  gmst_pkg::entry_t             mem [gmst_pkg::QDEPTH];
  logic [gmst_pkg::QAW-1:0]     wr_ptr;
  logic [gmst_pkg::QAW-1:0]     rd_ptr;
  logic [gmst_pkg::QCW-1:0]     count;

  assign full  = (count == gmst_pkg::QCW'(gmst_pkg::QDEPTH));
  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + gmst_pkg::QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + gmst_pkg::QAW'(1);
      end
      count <= count + gmst_pkg::QCW'(push) - gmst_pkg::QCW'(pop);
    end
  end

endmodule
`default_nettype wire

### sv/gmst_back.sv
`default_nettype none
module gmst_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_valid,
  input  wire gmst_pkg::entry_t             q_head,
  output logic                              q_pop,
  output logic                              out_vld,
  input  wire logic                         out_rdy,
  output logic [gmst_pkg::ROW_W-1:0]        out_row,
  output logic [gmst_pkg::COL_W-1:0]        out_col,
  output logic [gmst_pkg::METRIC_W-1:0]     out_metric,
  output logic                              out_last,
  output logic                              out_done
);

  logic [1:0]                    k;
  logic                          issue;
  logic                          is_last;
  logic                          o_free;
  logic                          p_free;
  gmst_pkg::res_kind_t           kind;

  logic [gmst_pkg::SAMPLE_W-1:0] xa;
  logic [gmst_pkg::SAMPLE_W-1:0] xb;
  logic [gmst_pkg::SAMPLE_W-1:0] ya;
  logic [gmst_pkg::SAMPLE_W-1:0] yb;
  gmst_pkg::diff_mode_t          xm;
  gmst_pkg::diff_mode_t          ym;
  logic [gmst_pkg::ROW_W-1:0]    sel_row;
  logic [gmst_pkg::COL_W-1:0]    sel_col;
  logic                          sel_done;

  logic signed [17:0]            d   [4];
  logic signed [35:0]            prd [4];

  logic                          p_vld;
  logic [gmst_pkg::SQ_W-1:0]     p_sq [4];
  logic [gmst_pkg::ROW_W-1:0]    p_row;
  logic [gmst_pkg::COL_W-1:0]    p_col;
  logic                          p_last;
  logic                          p_done;

  assign o_free  = !out_vld || out_rdy;
  assign p_free  = !p_vld || o_free;
  assign issue   = q_valid && p_free;
  assign is_last = (k == q_head.cls.n - 2'd1);
  assign q_pop   = issue && is_last;

  always_comb begin
    case (k)
      2'd0:    kind = q_head.cls.kind0;
      2'd1:    kind = q_head.cls.kind1;
      default: kind = q_head.cls.kind2;
    endcase
  end

  // Pick the two difference pairs of the result in hand.
  always_comb begin
    xa       = q_head.cur;
    xb       = q_head.up;
    xm       = gmst_pkg::DM_ZERO;
    ya       = q_head.cur;
    yb       = q_head.rs0;
    ym       = gmst_pkg::DM_ZERO;
    sel_row  = q_head.row;
    sel_col  = q_head.col;
    sel_done = 1'b0;
    case (kind)
      gmst_pkg::RES_UP: begin
        sel_row = q_head.row - gmst_pkg::ROW_W'(1);
        xb      = q_head.cls.r_is1 ? q_head.up : q_head.r2;
        xm      = q_head.cls.r_is1 ? gmst_pkg::DM_ONE : gmst_pkg::DM_CEN;
        case (q_head.cls.ey_sel)
          gmst_pkg::EY_FIRST: begin
            ya = q_head.pn;
            yb = q_head.up;
            ym = gmst_pkg::DM_ONE;
          end
          gmst_pkg::EY_LAST: begin
            ya = q_head.up;
            yb = q_head.pm1;
            ym = gmst_pkg::DM_ONE;
          end
          gmst_pkg::EY_MID: begin
            ya = q_head.pn;
            yb = q_head.pm1;
            ym = gmst_pkg::DM_CEN;
          end
          default: begin
            ym = gmst_pkg::DM_ZERO;
          end
        endcase
      end
      gmst_pkg::RES_LEFT: begin
        sel_col = q_head.col - gmst_pkg::COL_W'(1);
        xa      = q_head.rs0;
        xb      = q_head.pm1;
        xm      = q_head.cls.rgt1 ? gmst_pkg::DM_ONE : gmst_pkg::DM_ZERO;
        yb      = q_head.cls.c_is1 ? q_head.rs0 : q_head.rs1;
        ym      = q_head.cls.c_is1 ? gmst_pkg::DM_ONE : gmst_pkg::DM_CEN;
      end
      gmst_pkg::RES_HERE: begin
        sel_done = 1'b1;
        xm       = q_head.cls.rgt1 ? gmst_pkg::DM_ONE : gmst_pkg::DM_ZERO;
        ym       = q_head.cls.cgt1 ? gmst_pkg::DM_ONE : gmst_pkg::DM_ZERO;
      end
      default: begin
        sel_done = 1'b0;
      end
    endcase
  end

  always_comb begin
    d[0] = gmst_pkg::comp_diff(xa[15:0],  xb[15:0],  xm);
    d[1] = gmst_pkg::comp_diff(xa[31:16], xb[31:16], xm);
    d[2] = gmst_pkg::comp_diff(ya[15:0],  yb[15:0],  ym);
    d[3] = gmst_pkg::comp_diff(ya[31:16], yb[31:16], ym);
    for (int i = 0; i < 4; i++) begin
      prd[i] = d[i] * d[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k       <= '0;
      p_vld   <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (issue) begin
        k <= is_last ? 2'd0 : k + 2'd1;
      end
      if (p_free) begin
        p_vld <= issue;
      end
      if (o_free) begin
        out_vld <= p_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      for (int i = 0; i < 4; i++) begin
        p_sq[i] <= prd[i][gmst_pkg::SQ_W-1:0];
      end
      p_row  <= sel_row;
      p_col  <= sel_col;
      p_last <= is_last;
      p_done <= sel_done;
    end
    if (p_vld && o_free) begin
      out_metric <= gmst_pkg::METRIC_W'(p_sq[0]) + gmst_pkg::METRIC_W'(p_sq[1])
                  + gmst_pkg::METRIC_W'(p_sq[2]) + gmst_pkg::METRIC_W'(p_sq[3]);
      out_row    <= p_row;
      out_col    <= p_col;
      out_last   <= p_last;
      out_done   <= p_done;
    end
  end

endmodule
`default_nettype wire

### sv/grid_gradient_metric_stencil.sv
// Gradient-magnitude stencil over a row-major grid of complex Q1.15 samples.
// Input stream (s_t*): one sample per transfer, s_tdata = {im, re}.
// Output stream (m_t*): one result per transfer for a grid position, with its
// row, column and |d/dx|^2 + |d/dy|^2 scaled by 2^32; m_tlast marks the last
// result caused by one input, m_tuser marks the final position of the frame.
// APB port: row count at 0x0, column count at 0x4; any write restarts the
// frame at the origin. Write only while the block is idle.
// Path: a transfer is registered in the front stage, then goes through the
// queue, the product stage and the output register.
// Throughput: one sample per cycle outside the last row while the queue has
// room (each causes at most one result); in the last row a sample past the
// first column causes two results when the grid has more than one row (three
// at the frame end), and the back end issues one result per cycle while the
// output is not stalled, so that row takes in samples more slowly.
// Reset: registers go to a 1x1 grid, position to the origin, all pipeline
// stages and the 4-entry queue empty. The line stores are not cleared: every
// word used was written earlier in the same frame.
// Stall: a stalled output holds its result; the queue then fills and the
// front end drops s_tready until room opens.
`default_nettype none
`include "assert_macros.svh"
module grid_gradient_metric_stencil #(
  parameter int MAX_COLS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [15:0] sample_re, [31:16] sample_im
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // [15:0] out_row, [25:16] out_col,
                                      // [61:26] metric_value, [63:62] zero
  output logic             m_tlast,   // last_of_run
  output logic             m_tuser,   // [0] frame_done
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CW   = $clog2(MAX_COLS);
  localparam int CNTW = (CW + 1 > 11) ? CW + 1 : 11;

  logic [15:0]                       row_count;
  logic [10:0]                       col_count;
  logic                              cfg_wr;
  logic [gmst_pkg::ROW_W-1:0]        eff_rows;
  logic [CW:0]                       eff_cols;
  logic [CNTW-1:0]                   cc_ext;

  logic                              q_push;
  logic                              q_full;
  logic                              q_pop;
  logic                              q_valid;
  gmst_pkg::entry_t                  q_entry;
  gmst_pkg::entry_t                  q_head;

  logic [gmst_pkg::ROW_W-1:0]        out_row;
  logic [gmst_pkg::COL_W-1:0]        out_col;
  logic [gmst_pkg::METRIC_W-1:0]     out_metric;

  // Register file: write on the access cycle, no wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? {21'd0, col_count} : {16'd0, row_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= 16'd1;
      col_count <= 11'd1;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        col_count <= pwdata[10:0];
      end else begin
        row_count <= pwdata[15:0];
      end
    end
  end

  // Zero counts act as one; clamp the column count to the line store size.
  always_comb begin
    cc_ext   = CNTW'(col_count);
    eff_rows = (row_count == 16'd0) ? 16'd1 : row_count;
    if (col_count == 11'd0) begin
      eff_cols = (CW + 1)'(1);
    end else if (cc_ext > CNTW'(MAX_COLS)) begin
      eff_cols = (CW + 1)'(MAX_COLS);
    end else begin
      eff_cols = (CW + 1)'(cc_ext);
    end
  end

  gmst_front #(.MAX_COLS(MAX_COLS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .restart  (cfg_wr),
    .eff_rows (eff_rows),
    .eff_cols (eff_cols),
    .s_valid  (s_tvalid),
    .s_data   (s_tdata),
    .s_ready  (s_tready),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  // Decouple classification from the result sequencer.
  gmst_fifo u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  gmst_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_vld    (m_tvalid),
    .out_rdy    (m_tready),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_metric (out_metric),
    .out_last   (m_tlast),
    .out_done   (m_tuser)
  );

  assign m_tdata = {2'b00, out_metric, out_col, out_row};

  // The frame-end result always closes its run.
  `GMST_ASSERT_IMPLY(a_done_is_last, m_tvalid && m_tuser, m_tlast, "frame end result not last of run")
  // The metric never exceeds four full-scale one-sided squares.
  `GMST_ASSERT_IMPLY(a_metric_range, m_tvalid, m_tdata[61:26] <= 36'd68717379600, "metric out of range")
  // Results of one run leave back to back: the next one waits in the product stage.
  `GMST_ASSERT_NEXT(a_run_continues, m_tvalid && m_tready && !m_tlast, m_tvalid, "gap inside a run")

endmodule
`default_nettype wire

### bench/grid_gradient_metric_stencil_tb.sv
`timescale 1ns / 100ps

module grid_gradient_metric_stencil_tb;

  localparam int MAX_COLS = 1024;

  // Percent of cycles in which each side idles outside burst stretches.
  localparam int IDLE_PCT = 25;
  // Margins after the last result, before touching a register and before the
  // final verdict.
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 16;
  // Long receiver hold-off, long enough to fill the 4-entry result queue.
  localparam int HOLD_CYCLES   = 80;
  // Longest quiet stretch in a correct run is the receiver hold-off plus a
  // settle pause; take that many times over.
  localparam int STUCK_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 180;
  localparam int SAT_ITEMS     = 8;

  // One-sided horizontal difference between the two extremes, both parts.
  localparam logic [gmst_pkg::METRIC_W-1:0] METRIC_EDGE_MAX = 36'd34358689800;
  // Both directions at full swing: the largest value the block can give.
  localparam logic [gmst_pkg::METRIC_W-1:0] METRIC_MAX      = 36'd68717379600;

  localparam logic [31:0] SMP_MAX = {16'h7FFF, 16'h7FFF};
  localparam logic [31:0] SMP_MIN = {16'h8000, 16'h8000};

  typedef enum logic [0:0] {
    REG_ROWS,
    REG_COLS
  } grid_reg_t;

  typedef enum logic [1:0] {
    DK_SAMPLE,
    DK_SET_ROWS,
    DK_SET_COLS
  } dir_kind_t;

  // One directed step: a sample transfer or a register write. A typed metric
  // overrides the computed one for every result the sample causes.
  typedef struct packed {
    dir_kind_t                     kind;
    logic [31:0]                   value;
    logic                          typed;
    logic [gmst_pkg::METRIC_W-1:0] metric;
  } dir_row_t;

  typedef struct packed {
    logic [gmst_pkg::ROW_W-1:0]    row;
    logic [gmst_pkg::COL_W-1:0]    col;
    logic [gmst_pkg::METRIC_W-1:0] metric;
    logic                          last;
    logic                          done;
  } grad_result_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;   // [15:0] sample_re, [31:16] sample_im
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;         // [15:0] out_row, [25:16] out_col, [61:26] metric_value
  logic        m_tlast;         // last_of_run
  logic        m_tuser;         // [0] frame_done
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  // Gradient predictor state: both line stores, the last two samples of the
  // current row, the grid position and the two size registers.
  logic [31:0] line_mem [0:2*MAX_COLS-1];
  logic [31:0] prev1;
  logic [31:0] prev2;
  int unsigned pos_row  = 0;
  int unsigned pos_col  = 0;
  int unsigned rows_reg = 1;
  int unsigned cols_reg = 1;

  grad_result_t step_res [0:2];
  grad_result_t grad_q [$];
  dir_row_t     dir_tab [$];

  int mismatches   = 0;
  int stuck_cycles = 0;
  bit burst_mode   = 1'b0;
  int hold_asks    = 0;
  int hold_taken   = 0;
  int hold_left    = 0;

  grid_gradient_metric_stencil #(
    .MAX_COLS(MAX_COLS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Squared magnitude of a complex difference in units of 2^-32. A one-sided
  // difference counts twice against the halved central one.
  function automatic longint diff_sq(input logic [31:0] a, input logic [31:0] b,
                                     input gmst_pkg::diff_mode_t m);
    longint dr;
    longint di;
    dr = longint'($signed(a[15:0])) - longint'($signed(b[15:0]));
    di = longint'($signed(a[31:16])) - longint'($signed(b[31:16]));
    if (m == gmst_pkg::DM_ZERO) return 0;
    if (m == gmst_pkg::DM_ONE) begin
      dr = dr * 2;
      di = di * 2;
    end
    return dr * dr + di * di;
  endfunction

  function automatic void put_res(input int k, input int unsigned row,
                                  input int unsigned col, input longint val,
                                  input logic done);
    step_res[k].row    = row[gmst_pkg::ROW_W-1:0];
    step_res[k].col    = col[gmst_pkg::COL_W-1:0];
    step_res[k].metric = val[gmst_pkg::METRIC_W-1:0];
    step_res[k].last   = 1'b0;
    step_res[k].done   = done;
  endfunction

  // Advance the gradient predictor by one sample; fill step_res and return
  // how many results the sample causes.
  function automatic int grad_step(input logic [31:0] cur);
    int unsigned nr;
    int unsigned nc;
    int unsigned r;
    int unsigned c;
    int unsigned cb;
    int unsigned pb;
    longint      ex;
    longint      ey;
    int          n;
    n  = 0;
    nr = (rows_reg == 0) ? 1 : rows_reg;
    nc = (cols_reg == 0) ? 1 : ((cols_reg > MAX_COLS) ? MAX_COLS : cols_reg);
    r  = pos_row;
    c  = pos_col;
    if (r >= nr || c >= nc) begin
      r = 0;
      c = 0;
    end
    cb = (r % 2) * MAX_COLS;
    pb = ((r + 1) % 2) * MAX_COLS;

    // Finish the position straight above: its whole neighborhood is known now.
    if (r >= 1) begin
      if (r == 1) ex = diff_sq(cur, line_mem[pb+c], gmst_pkg::DM_ONE);
      else        ex = diff_sq(cur, line_mem[cb+c], gmst_pkg::DM_CEN);
      if (nc == 1)          ey = 0;
      else if (c == 0)      ey = diff_sq(line_mem[pb+1], line_mem[pb], gmst_pkg::DM_ONE);
      else if (c == nc - 1) ey = diff_sq(line_mem[pb+c], line_mem[pb+c-1], gmst_pkg::DM_ONE);
      else                  ey = diff_sq(line_mem[pb+c+1], line_mem[pb+c-1], gmst_pkg::DM_CEN);
      put_res(n, r - 1, c, ex + ey, 1'b0);
      n++;
    end

    // Last row: the left neighbor is complete, and the corner at the row end.
    if (r == nr - 1) begin
      if (c >= 1) begin
        ex = 0;
        if (nr > 1) ex = diff_sq(prev1, line_mem[pb+c-1], gmst_pkg::DM_ONE);
        if (c == 1) ey = diff_sq(cur, prev1, gmst_pkg::DM_ONE);
        else        ey = diff_sq(cur, prev2, gmst_pkg::DM_CEN);
        put_res(n, r, c - 1, ex + ey, 1'b0);
        n++;
      end
      if (c == nc - 1) begin
        ex = 0;
        ey = 0;
        if (nr > 1) ex = diff_sq(cur, line_mem[pb+c], gmst_pkg::DM_ONE);
        if (nc > 1) ey = diff_sq(cur, prev1, gmst_pkg::DM_ONE);
        put_res(n, r, c, ex + ey, 1'b1);
        n++;
      end
    end
    if (n > 0) step_res[n-1].last = 1'b1;

    line_mem[cb+c] = cur;
    prev2 = prev1;
    prev1 = cur;
    c++;
    if (c >= nc) begin
      c = 0;
      r++;
      if (r >= nr) r = 0;
    end
    pos_row = r;
    pos_col = c;
    return n;
  endfunction

  function automatic logic [15:0] rand_part();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_sample();
    return {rand_part(), rand_part()};
  endfunction

  function automatic void add_row(input dir_kind_t kind, input logic [31:0] value,
                                  input logic typed,
                                  input logic [gmst_pkg::METRIC_W-1:0] metric);
    dir_row_t e;
    e.kind   = kind;
    e.value  = value;
    e.typed  = typed;
    e.metric = metric;
    dir_tab.push_back(e);
  endfunction

  // Offer one sample, with random idle cycles ahead of it outside burst stretches;
  // on its transfer, queue the results it should cause.
  task automatic send_sample(input logic [31:0] smp, input logic typed,
                             input logic [gmst_pkg::METRIC_W-1:0] metric);
    int n;
    int k;
    while (!burst_mode && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    do @(posedge clk); while (!s_tready);
    n = grad_step(smp);
    for (k = 0; k < n; k++) begin
      if (typed) step_res[k].metric = metric;
      grad_q.push_back(step_res[k]);
    end
  endtask

  // Drop valid, wait out every pending result plus a settle pause.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (grad_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write a size register on an idle block, mirror it in the predictor (which
  // also restarts the frame) and read it back.
  task automatic set_reg(input grid_reg_t idx, input logic [31:0] value);
    logic [31:0] rd;
    logic [31:0] want;
    settle();
    apb_access(1'b1, {idx, 2'b00}, value, rd);
    if (idx == REG_ROWS) rows_reg = value[15:0];
    else                 cols_reg = value[10:0];
    pos_row = 0;
    pos_col = 0;
    want = (idx == REG_ROWS) ? {16'b0, value[15:0]} : {21'b0, value[10:0]};
    apb_access(1'b0, {idx, 2'b00}, '0, rd);
    if (rd !== want) begin
      $error("prdata: expected %0d, actual %0d", want, rd);
      mismatches++;
    end
  endtask

  // Receiver: random back-pressure, none in burst stretches, and a long
  // hold-off whenever the stimulus asks for one.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_asks) begin
      hold_taken <= hold_asks;
      hold_left  <= HOLD_CYCLES;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= burst_mode || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk) begin
    grad_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (grad_q.size() == 0) begin
        $error("unexpected result: row %0d col %0d metric %0d",
               m_tdata[15:0], m_tdata[25:16], m_tdata[61:26]);
        mismatches++;
      end else begin
        want = grad_q.pop_front();
        if (m_tdata[15:0] !== want.row) begin
          $error("out_row: expected %0d, actual %0d", want.row, m_tdata[15:0]);
          mismatches++;
        end
        if (m_tdata[25:16] !== want.col) begin
          $error("out_col: expected %0d, actual %0d", want.col, m_tdata[25:16]);
          mismatches++;
        end
        if (m_tdata[61:26] !== want.metric) begin
          $error("metric_value: expected %0d, actual %0d", want.metric, m_tdata[61:26]);
          mismatches++;
        end
        if (m_tlast !== want.last) begin
          $error("last_of_run: expected %0d, actual %0d", want.last, m_tlast);
          mismatches++;
        end
        if (m_tuser !== want.done) begin
          $error("frame_done: expected %0d, actual %0d", want.done, m_tuser);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("[grid_gradient_metric_stencil] ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int sent;
    int phase;
    int nr;
    int nc;
    int count;
    sent  = 0;
    phase = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // After reset the grid is 1x1: every sample is its own frame, metric zero.
    add_row(DK_SAMPLE,   SMP_MAX, 1'b1, '0);
    add_row(DK_SAMPLE,   SMP_MIN, 1'b1, '0);
    // Zero sizes fall back to one row and one column.
    add_row(DK_SET_ROWS, 32'd0, 1'b0, '0);
    add_row(DK_SET_COLS, 32'd0, 1'b0, '0);
    add_row(DK_SAMPLE,   32'h1234_ABCD, 1'b1, '0);
    // Single row of two: one-sided horizontal difference at full swing, two results.
    add_row(DK_SET_COLS, 32'd2, 1'b0, '0);
    add_row(DK_SAMPLE,   SMP_MIN, 1'b0, '0);
    add_row(DK_SAMPLE,   SMP_MAX, 1'b1, METRIC_EDGE_MAX);
    // 2x2 checkerboard of extremes: every position reaches the maximum.
    add_row(DK_SET_ROWS, 32'd2, 1'b0, '0);
    add_row(DK_SAMPLE,   SMP_MAX, 1'b0, '0);
    add_row(DK_SAMPLE,   SMP_MIN, 1'b0, '0);
    add_row(DK_SAMPLE,   SMP_MIN, 1'b1, METRIC_MAX);
    add_row(DK_SAMPLE,   SMP_MAX, 1'b1, METRIC_MAX);
    // 3x3, broken off after four samples by a write that restarts the frame.
    add_row(DK_SET_ROWS, 32'd3, 1'b0, '0);
    add_row(DK_SET_COLS, 32'd3, 1'b0, '0);
    add_row(DK_SAMPLE,   32'h7FFF_0000, 1'b0, '0);
    add_row(DK_SAMPLE,   32'h8000_FFFF, 1'b0, '0);
    add_row(DK_SAMPLE,   32'h0001_7FFF, 1'b0, '0);
    add_row(DK_SAMPLE,   32'hFFFF_8000, 1'b0, '0);
    add_row(DK_SET_COLS, 32'd3, 1'b0, '0);
    // Full 3x3 frame: central differences in the middle row and column.
    add_row(DK_SAMPLE,   32'h0000_0000, 1'b0, '0);
    add_row(DK_SAMPLE,   32'h4000_C000, 1'b0, '0);
    add_row(DK_SAMPLE,   32'h7FFF_8000, 1'b0, '0);
    add_row(DK_SAMPLE,   32'hC000_4000, 1'b0, '0);
    add_row(DK_SAMPLE,   32'h8000_7FFF, 1'b0, '0);
    add_row(DK_SAMPLE,   32'h0123_FEDC, 1'b0, '0);
    add_row(DK_SAMPLE,   32'hFFFF_0001, 1'b0, '0);
    add_row(DK_SAMPLE,   32'h5555_AAAA, 1'b0, '0);
    add_row(DK_SAMPLE,   32'hAAAA_5555, 1'b0, '0);

    foreach (dir_tab[i]) begin
      case (dir_tab[i].kind)
        DK_SET_ROWS: begin
          set_reg(REG_ROWS, dir_tab[i].value);
        end
        DK_SET_COLS: begin
          set_reg(REG_COLS, dir_tab[i].value);
        end
        default: begin
          send_sample(dir_tab[i].value, dir_tab[i].typed, dir_tab[i].metric);
        end
      endcase
    end

    // Random grids: mostly whole frames (one or two back to back, so the
    // position wraps), now and then a frame cut short by the next write.
    while (sent < RANDOM_ITEMS) begin
      nr = ($urandom_range(3) == 0) ? 1 : $urandom_range(5, 2);
      nc = ($urandom_range(4) == 0) ? 1 : $urandom_range(8, 2);
      if (phase == 1) begin
        // Fixed grid with no idling and a long receiver hold-off: the result
        // queue fills and the block has to stall its input.
        nr = 3;
        nc = 6;
      end
      burst_mode = (phase == 0 || phase == 1);
      if ($urandom_range(1) == 0) begin
        set_reg(REG_ROWS, nr);
        set_reg(REG_COLS, nc);
      end else begin
        set_reg(REG_COLS, nc);
        set_reg(REG_ROWS, nr);
      end
      if (phase == 1) hold_asks++;
      if (phase != 1 && nr * nc > 1 && $urandom_range(4) == 0)
        count = $urandom_range(nr * nc - 1, 1);
      else
        count = nr * nc * ((phase == 1) ? 2 : $urandom_range(2, 1));
      if (count > RANDOM_ITEMS - sent) count = RANDOM_ITEMS - sent;
      repeat (count) send_sample(rand_sample(), 1'b0, '0);
      sent += count;
      phase++;
    end
    burst_mode = 1'b0;

    // Column count above the line store width saturates; single row, so
    // every sample past the first column completes its left neighbor.
    set_reg(REG_ROWS, 32'd1);
    set_reg(REG_COLS, 32'd2047);
    repeat (SAT_ITEMS) send_sample(rand_sample(), 1'b0, '0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[grid_gradient_metric_stencil] OK");
    end else begin
      $display("[grid_gradient_metric_stencil] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/gmst_pkg.sv
sv/gmst_line_mem.sv
sv/gmst_front.sv
sv/gmst_fifo.sv
sv/gmst_back.sv
sv/grid_gradient_metric_stencil.sv
bench/grid_gradient_metric_stencil_tb.sv
